// ----- rtl/core/binomial_mod_prime_engine_macros.svh -----
// Assertion macros shared by the binomial engine RTL.
// No dependencies.
`ifndef BINOMIAL_MOD_PRIME_ENGINE_MACROS_SVH
`define BINOMIAL_MOD_PRIME_ENGINE_MACROS_SVH
// assert that a condition implies a consequence in the same cycle
`define BMP_ASSERT_IMP(lbl, clk, rstn, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) else $error(msg);
// assert that a condition implies a consequence in the next cycle
`define BMP_ASSERT_NXT(lbl, clk, rstn, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) else $error(msg);
`endif

// ----- rtl/core/bmpe_pkg.sv -----
// Package for the binomial engine: widths, action codes, state types.
// No dependencies.
`timescale 1ns / 1ps
package bmpe_pkg;
  localparam int MW = 31;
  localparam int TS = 1024;
  localparam int AW = 10;
  localparam int CW = 11;
  localparam int MCW = 5;
  localparam logic [MW-1:0] MOD_RESET = 31'd1000000007;

  typedef enum logic [2:0] {
    ACT_FACT = 3'd0, ACT_INV = 3'd1, ACT_IFACT = 3'd2,
    ACT_BINOM = 3'd3, ACT_ARR = 3'd4, ACT_REP = 3'd5
  } action_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHECK, ST_F_DIV, ST_F_RD, ST_F_RDW, ST_F_M1, ST_F_M2, ST_F_M3,
    ST_F_WR, ST_Q_RD, ST_Q_RDW, ST_Q_M1, ST_Q_M2, ST_Q_M3, ST_Q_M3W, ST_OUT
  } state_e;
endpackage

// ----- rtl/core/bmpe_if.sv -----
// Valid/ready channel interfaces for query items and result items.
// Depends on bmpe_pkg.
`timescale 1ns / 1ps
interface bmpe_query_if;
  import bmpe_pkg::*;
  logic valid;
  logic ready;
  logic [2:0] action;
  logic [AW-1:0] n;
  logic [AW-1:0] k;
  modport source (output valid, action, n, k, input ready);
  modport sink (input valid, action, n, k, output ready);
endinterface

interface bmpe_result_if;
  import bmpe_pkg::*;
  logic valid;
  logic ready;
  logic [MW-1:0] value;
  logic error;
  modport source (output valid, value, error, input ready);
  modport sink (input valid, value, error, output ready);
endinterface

// ----- rtl/core/bmpe_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module bmpe_ram #(
  parameter int Width = 31,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ----- rtl/core/bmpe_mulmod.sv -----
// Bit-serial modular multiplier: one multiplier bit per cycle, shift and add.
// Depends on bmpe_pkg.
`timescale 1ns / 1ps
module bmpe_mulmod (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [bmpe_pkg::MW-1:0] a_i,
  input  logic [bmpe_pkg::MW-1:0] b_i,
  input  logic [bmpe_pkg::MW-1:0] m_i,
  output logic                  busy_o,
  output logic [bmpe_pkg::MW-1:0] r_o
);
  import bmpe_pkg::*;
  logic [MW-1:0] a_q, a_d, b_q, b_d, r_q, r_d;
  logic busy_q, busy_d;
  logic [MW:0] sr, sa;

  always_comb begin
    a_d = a_q; b_d = b_q; r_d = r_q; busy_d = busy_q;
    sr = {1'b0, r_q} + {1'b0, a_q};
    sa = {1'b0, a_q} + {1'b0, a_q};
    if (start_i) begin
      a_d = a_i; b_d = b_i; r_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      if (b_q[0]) begin
        r_d = (sr >= {1'b0, m_i}) ? MW'(sr - {1'b0, m_i}) : sr[MW-1:0];
      end
      a_d = (sa >= {1'b0, m_i}) ? MW'(sa - {1'b0, m_i}) : sa[MW-1:0];
      b_d = b_q >> 1;
      if (b_q == '0) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end
  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; r_q <= r_d;
  end
  assign busy_o = busy_q;
  assign r_o = r_q;
endmodule

// ----- rtl/core/bmpe_divmod.sv -----
// Bit-serial divider of the modulus by a table index: quotient and remainder.
// Depends on bmpe_pkg.
`timescale 1ns / 1ps
module bmpe_divmod (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [bmpe_pkg::MW-1:0] num_i,
  input  logic [bmpe_pkg::AW-1:0] den_i,
  output logic                    busy_o,
  output logic [bmpe_pkg::MW-1:0] quo_o,
  output logic [bmpe_pkg::AW-1:0] rem_o
);
  import bmpe_pkg::*;
  logic [MW-1:0] q_q, q_d;
  logic [AW:0] r_q, r_d, sh;
  logic [MCW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d;

  always_comb begin
    q_d = q_q; r_d = r_q; cnt_d = cnt_q; busy_d = busy_q;
    sh = {r_q[AW-1:0], q_q[MW-1]};
    if (start_i) begin
      q_d = num_i; r_d = '0; cnt_d = MCW'(MW - 1); busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in one numerator bit, subtract when it fits
      if (sh >= {1'b0, den_i}) begin
        r_d = sh - {1'b0, den_i};
        q_d = {q_q[MW-2:0], 1'b1};
      end else begin
        r_d = sh;
        q_d = {q_q[MW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end
  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d; cnt_q <= cnt_d;
  end
  assign busy_o = busy_q;
  assign quo_o = q_q;
  assign rem_o = r_q[AW-1:0];
endmodule

// ----- rtl/core/binomial_mod_prime_engine.sv -----
// Time from accept to result valid depends on the action: factorial, inverse and inverse
// factorial only read the table, binomial and repetition take two modular products and
// arrangement three, on the bit-serial multiplier; each new table entry adds a division and three products.
// Throughput: one item at a time; the next is taken the cycle after the result is accepted.
// Reset (async, active low) restores modulus 1000000007 and clears the fill
// count; table contents are left undefined and rebuilt on demand.
`timescale 1ns / 1ps
`include "binomial_mod_prime_engine_macros.svh"
module binomial_mod_prime_engine (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [bmpe_pkg::MW-1:0] cfg_wdata_i,
  bmpe_query_if.sink              query,
  bmpe_result_if.source           result
);
  import bmpe_pkg::*;

  state_e state_q, state_d;
  logic [MW-1:0] mod_q, pm;
  logic [CW-1:0] filled_q, filled_d;
  logic [AW-1:0] j_q, j_d, top_q, top_d;
  logic [2:0] act_q, act_d;
  logic [AW-1:0] a_q, a_d, b_q, b_d, kk_q, kk_d;
  logic [MW-1:0] acc_q, acc_d, quo_q, quo_d, val_q, val_d, prev_q, prev_d;
  logic [AW-1:0] rem_q, rem_d;
  logic err_q, err_d, ovl_q, ovl_d;
  logic [1:0] ph_q, ph_d;
  logic [AW:0] apk;

  // table ports
  logic f_we, i_we, x_we;
  logic [AW-1:0] f_addr, i_addr, x_addr;
  logic [MW-1:0] f_wd, i_wd, x_wd, f_rd, i_rd, x_rd;

  logic m_start, m_busy;
  logic [MW-1:0] m_a, m_b, m_r;
  logic d_start, d_busy;
  logic [MW-1:0] d_quo;
  logic [AW-1:0] d_rem;

  assign pm = (mod_q < MW'(2)) ? MW'(2) : mod_q;

  bmpe_ram #(.Width(MW), .Depth(TS)) u_fact (
    .clk_i, .we_i(f_we), .addr_i(f_addr), .wdata_i(f_wd), .rdata_o(f_rd));
  bmpe_ram #(.Width(MW), .Depth(TS)) u_inv (
    .clk_i, .we_i(i_we), .addr_i(i_addr), .wdata_i(i_wd), .rdata_o(i_rd));
  bmpe_ram #(.Width(MW), .Depth(TS)) u_ifact (
    .clk_i, .we_i(x_we), .addr_i(x_addr), .wdata_i(x_wd), .rdata_o(x_rd));

  bmpe_mulmod u_mul (
    .clk_i, .rst_ni, .start_i(m_start), .a_i(m_a), .b_i(m_b), .m_i(pm),
    .busy_o(m_busy), .r_o(m_r));
  bmpe_divmod u_div (
    .clk_i, .rst_ni, .start_i(d_start), .num_i(pm), .den_i(j_q),
    .busy_o(d_busy), .quo_o(d_quo), .rem_o(d_rem));

  assign apk = {1'b0, query.n} + {1'b0, query.k} - 1'b1;

  always_comb begin
    state_d = state_q; filled_d = filled_q; j_d = j_q; top_d = top_q;
    act_d = act_q; a_d = a_q; b_d = b_q; kk_d = kk_q; acc_d = acc_q;
    quo_d = quo_q; rem_d = rem_q; val_d = val_q; err_d = err_q; ovl_d = ovl_q;
    prev_d = prev_q; ph_d = ph_q;
    f_we = 1'b0; i_we = 1'b0; x_we = 1'b0;
    f_addr = j_q; i_addr = j_q; x_addr = j_q;
    f_wd = acc_q; i_wd = acc_q; x_wd = acc_q;
    m_start = 1'b0; m_a = acc_q; m_b = acc_q; d_start = 1'b0;
    query.ready = 1'b0;
    result.valid = 1'b0;
    case (state_q)
      ST_IDLE: begin
        query.ready = 1'b1;
        if (query.valid) begin
          act_d = query.action; kk_d = query.k; err_d = 1'b0; val_d = '0;
          ovl_d = 1'b0;
          a_d = query.n; b_d = query.k;
          if (query.action == ACT_REP) begin
            a_d = apk[AW-1:0]; ovl_d = apk[AW];
          end
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        top_d = a_q; j_d = filled_q[AW-1:0] + 1'b1;
        state_d = ST_OUT;
        case (act_q)
          ACT_FACT, ACT_INV, ACT_IFACT: begin
            ph_d = 2'd0; state_d = ST_F_DIV;
          end
          ACT_BINOM, ACT_ARR: begin
            if (b_q <= a_q) begin
              ph_d = 2'd0; state_d = ST_F_DIV;
            end
          end
          ACT_REP: begin
            if (ovl_q) begin
              // wrapped sum: n and k both zero give 1, otherwise the index is off the table
              if (kk_q == AW'(0)) begin
                val_d = MW'(1);
              end else begin
                err_d = 1'b1;
              end
            end else if (b_q <= a_q) begin
              ph_d = 2'd0; state_d = ST_F_DIV;
            end
          end
          default: ;
        endcase
      end
      ST_F_DIV: begin
        if ({1'b0, j_q} > filled_q && j_q <= top_q && j_q != AW'(0)) begin
          if (ph_q == 2'd0) begin
            d_start = 1'b1; ph_d = 2'd1;
          end else if (!d_busy && ph_q == 2'd1) begin
            quo_d = d_quo; rem_d = d_rem; state_d = ST_F_RD;
          end
        end else begin
          if (top_q > filled_q[AW-1:0] || filled_q == '0) begin
            if ({1'b0, top_q} > filled_q) filled_d = {1'b0, top_q};
          end
          state_d = ST_Q_RD; ph_d = 2'd0;
        end
      end
      ST_F_RD: begin
        f_addr = j_q - 1'b1; x_addr = j_q - 1'b1; i_addr = rem_q;
        state_d = ST_F_RDW;
      end
      ST_F_RDW: begin
        // fact[j] = fact[j-1]*j; entry zero of the tables is never written, the seed 1 is used in its place
        prev_d = (j_q == AW'(1)) ? MW'(1) : x_rd;
        acc_d = (rem_q == '0) ? MW'(1) : i_rd;
        m_start = 1'b1; m_a = (j_q == AW'(1)) ? MW'(1) : f_rd;
        m_b = (MW'(j_q) >= pm) ? MW'(MW'(j_q) - pm) : MW'(j_q);
        state_d = ST_F_M1;
      end
      ST_F_M1: begin
        if (!m_busy) begin
          f_we = 1'b1; f_wd = m_r;
          m_start = 1'b1; m_a = acc_q;
          m_b = (quo_q >= pm) ? quo_q - pm : quo_q;
          state_d = ST_F_M2;
        end
      end
      ST_F_M2: begin
        if (!m_busy) begin
          acc_d = (j_q == AW'(1)) ? MW'(1) : ((m_r == '0) ? '0 : pm - m_r);
          state_d = ST_F_M3;
        end
      end
      ST_F_M3: begin
        i_we = 1'b1; i_wd = acc_q;
        m_start = 1'b1; m_a = prev_q; m_b = acc_q;
        state_d = ST_F_WR;
      end
      ST_F_WR: begin
        if (!m_busy) begin
          x_we = 1'b1; x_wd = m_r;
          filled_d = {1'b0, j_q};
          j_d = j_q + 1'b1; ph_d = 2'd0;
          state_d = (j_q == top_q) ? ST_Q_RD : ST_F_DIV;
        end
      end
      ST_Q_RD: begin
        f_addr = a_q; i_addr = a_q;
        // single-index queries ignore k
        x_addr = (act_q == ACT_IFACT) ? a_q : a_q - b_q;
        state_d = ST_Q_RDW;
      end
      ST_Q_RDW: begin
        case (act_q)
          ACT_FACT:  begin val_d = (a_q == '0) ? MW'(1) : f_rd; state_d = ST_OUT; end
          ACT_INV:   begin
            val_d = (a_q <= AW'(1)) ? MW'(1) : i_rd; state_d = ST_OUT;
          end
          ACT_IFACT: begin val_d = (a_q == '0) ? MW'(1) : x_rd; state_d = ST_OUT; end
          default: begin
            acc_d = (a_q == '0) ? MW'(1) : f_rd;
            prev_d = (a_q == b_q) ? MW'(1) : x_rd;
            state_d = ST_Q_M1;
          end
        endcase
      end
      ST_Q_M1: begin
        m_start = 1'b1; m_a = acc_q; m_b = prev_q;
        x_addr = b_q; f_addr = b_q;
        state_d = ST_Q_M2;
      end
      ST_Q_M2: begin
        if (ph_q == 2'd0) begin
          prev_d = (b_q == '0) ? MW'(1) : x_rd;
          quo_d = (b_q == '0) ? MW'(1) : f_rd;
          ph_d = 2'd1;
        end
        if (!m_busy && ph_q == 2'd1) begin
          m_start = 1'b1; m_a = m_r; m_b = prev_q;
          ph_d = 2'd0; state_d = ST_Q_M3;
        end
      end
      ST_Q_M3: begin
        if (!m_busy) begin
          val_d = m_r;
          if (act_q == ACT_ARR) begin
            m_start = 1'b1; m_a = m_r; m_b = quo_q; state_d = ST_Q_M3W;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_Q_M3W: begin
        if (!m_busy) begin
          val_d = m_r; state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        result.valid = 1'b1;
        if (result.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    if (cfg_we_i) filled_d = '0;
  end

  assign result.value = err_q ? '0 : val_q;
  assign result.error = err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mod_q <= MOD_RESET;
      filled_q <= '0;
      ph_q <= 2'd0;
    end else begin
      state_q <= state_d;
      filled_q <= filled_d;
      ph_q <= ph_d;
      if (cfg_we_i) mod_q <= cfg_wdata_i;
    end
  end
  always_ff @(posedge clk_i) begin
    j_q <= j_d; top_q <= top_d; act_q <= act_d; a_q <= a_d; b_q <= b_d;
    kk_q <= kk_d; acc_q <= acc_d; quo_q <= quo_d; rem_q <= rem_d;
    val_q <= val_d; err_q <= err_d; ovl_q <= ovl_d; prev_q <= prev_d;
  end

  `BMP_ASSERT_IMP(a_rdy_idle, clk_i, rst_ni, query.ready, state_q == ST_IDLE, "ready outside idle")
  `BMP_ASSERT_IMP(a_err_zero, clk_i, rst_ni, result.valid && result.error, result.value == '0, "error with value")
  `BMP_ASSERT_NXT(a_acc, clk_i, rst_ni, query.valid && query.ready, state_q == ST_CHECK, "no check after accept")
endmodule
